/* rtl/mono_oled_frame_buffer_top_macros.svh */
// Assertion macros for the mono OLED frame buffer.
`ifndef MONO_OLED_FRAME_BUFFER_TOP_MACROS_SVH
`define MONO_OLED_FRAME_BUFFER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is high.
`define MOFB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define MOFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MOFB_ASSERT(lbl, clk, rst, prop, msg)
`define MOFB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/mofb_pkg.sv */
// Types and constants shared by the mono OLED frame buffer.
`timescale 1ns / 1ps
package mofb_pkg;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] column;
      logic [7:0] row;
      logic       set_pixel;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       is_data;
      logic       frame_end;
   } rsp_type;

   localparam logic [1:0] KIND_DRAW  = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_EMIT  = 2'd2;

   localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

   // Slot positions within one page of the refresh stream
   localparam int SLOT_PAGE_CMD = 0;
   localparam int SLOT_COL_LOW  = 1;
   localparam int SLOT_COL_HIGH = 2;
   localparam int HEADER_SLOTS  = 3;

endpackage

/* rtl/mono_oled_frame_buffer_top.sv */
// Top level of the mono OLED frame buffer: frame store and refresh stream.
`timescale 1ns / 1ps
`include "mono_oled_frame_buffer_top_macros.svh"

// Monochrome OLED frame buffer, PAGES pages by COLUMNS column bytes (128x64
// pixels by default), held in one synchronous RAM with a registered read.
// Request beats: kind 0 draws a pixel (read, then write back the modified
// byte; out-of-range coordinates change nothing), kind 1 clears the store and
// rewinds the refresh stream, kind 2 returns the next refresh byte, kind 3 is
// dropped. For each page the stream gives 0xB0+page, 0x00, 0x10 as commands,
// then COLUMNS data bytes, frame_end marking the last byte of the last page.
// A command byte, an off-panel draw and a dropped beat finish in the idle
// state; an on-panel draw also passes ST_DRAW_WR and a data byte ST_EMIT_RD.
// After reset and after each clear beat the block walks the RAM writing zeros,
// one byte a cycle through all PAGES*COLUMNS bytes (1024 by default), with req_ready
// low. req_ready is also low while a response beat waits and is not being
// taken in the same cycle.
module mono_oled_frame_buffer_top #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mofb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mofb_pkg::rsp_type rsp_data
);
   import mofb_pkg::*;

   localparam int DEPTH = PAGES * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int SW    = $clog2(COLUMNS + HEADER_SLOTS);

   // Controller states
   localparam logic [1:0] ST_CLEAR   = 2'd0;
   localparam logic [1:0] ST_IDLE    = 2'd1;
   localparam logic [1:0] ST_DRAW_WR = 2'd2;
   localparam logic [1:0] ST_EMIT_RD = 2'd3;

   localparam logic [SW-1:0] SLOT_LAST = SW'(COLUMNS + HEADER_SLOTS - 1);
   localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);
   localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [PW-1:0] page_ff, page_in;
   logic [SW-1:0] slot_ff, slot_in;

   // Draw context held for the write-back cycle; op_last_ff is the frame-end flag of an emit read
   logic [AW-1:0] op_addr_ff, op_addr_in;
   logic [7:0]    op_mask_ff, op_mask_in;
   logic          op_set_ff, op_set_in;
   logic          op_last_ff, op_last_in;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // Frame store
   logic [7:0]    mem [DEPTH];
   logic [7:0]    mem_rd_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]    mem_wd;

   logic          req_fire;
   logic          rsp_load;
   logic          draw_ok;
   logic [PW-1:0] draw_page;
   logic [AW-1:0] draw_addr;
   logic [AW-1:0] emit_addr;
   logic          emit_wrap;
   logic [7:0]    hdr_byte;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign draw_ok   = ({1'b0, req_data.column} < 9'(COLUMNS)) &&
                      ({1'b0, req_data.row} < 9'(8 * PAGES));
   assign draw_page = PAGE_LAST - req_data.row[3 +: PW];
   assign draw_addr = AW'(int'(draw_page) * COLUMNS + int'(req_data.column));
   assign emit_addr = AW'(int'(page_ff) * COLUMNS + int'(slot_ff) - HEADER_SLOTS);
   assign emit_wrap = (slot_ff == SLOT_LAST);

   always_comb begin
      if (slot_ff == SW'(SLOT_PAGE_CMD)) begin
         hdr_byte = CMD_PAGE_BASE + 8'(page_ff);
      end else if (slot_ff == SW'(SLOT_COL_LOW)) begin
         hdr_byte = CMD_COL_LOW;
      end else begin
         hdr_byte = CMD_COL_HIGH;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      page_in      = page_ff;
      slot_in      = slot_ff;
      op_addr_in   = op_addr_ff;
      op_mask_in   = op_mask_ff;
      op_set_in    = op_set_ff;
      op_last_in   = op_last_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = clr_addr_ff;
      mem_wd       = 8'h00;
      mem_re       = 1'b0;
      mem_ra       = emit_addr;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == ADDR_LAST) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.kind)
                  KIND_DRAW: begin
                     if (draw_ok) begin
                        mem_re     = 1'b1;
                        mem_ra     = draw_addr;
                        op_addr_in = draw_addr;
                        op_mask_in = 8'h80 >> req_data.row[2:0];
                        op_set_in  = req_data.set_pixel;
                        state_in   = ST_DRAW_WR;
                     end
                  end
                  KIND_CLEAR: begin
                     page_in     = '0;
                     slot_in     = '0;
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  KIND_EMIT: begin
                     slot_in = emit_wrap ? '0 : slot_ff + SW'(1);
                     if (emit_wrap) begin
                        page_in = (page_ff == PAGE_LAST) ? '0 : page_ff + PW'(1);
                     end
                     if (int'(slot_ff) < HEADER_SLOTS) begin
                        rsp_load    = 1'b1;
                        rsp_data_in = '{byte_out: hdr_byte, is_data: 1'b0,
                                        frame_end: 1'b0};
                     end else begin
                        mem_re     = 1'b1;
                        op_last_in = emit_wrap && (page_ff == PAGE_LAST);
                        state_in   = ST_EMIT_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRAW_WR: begin
            mem_we   = 1'b1;
            mem_wa   = op_addr_ff;
            mem_wd   = op_set_ff ? (mem_rd_ff | op_mask_ff) : (mem_rd_ff & ~op_mask_ff);
            state_in = ST_IDLE;
         end
         ST_EMIT_RD: begin
            // response register was free or drained when the beat was taken
            rsp_load    = 1'b1;
            rsp_data_in = '{byte_out: mem_rd_ff, is_data: 1'b1, frame_end: op_last_ff};
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         page_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         page_ff      <= page_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_addr_ff <= op_addr_in;
      op_mask_ff <= op_mask_in;
      op_set_ff  <= op_set_in;
      op_last_ff <= op_last_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MOFB_ASSERT(a_clear_restarts, clock, reset,
      (req_fire && req_data.kind == KIND_CLEAR) |=>
         (state_ff == ST_CLEAR && clr_addr_ff == '0 && page_ff == '0 && slot_ff == '0),
      "clear beat did not restart the sweep")
   `MOFB_ASSERT(a_rsp_no_overwrite, clock, reset,
      rsp_load |-> (!rsp_valid_ff || rsp_ready),
      "response overwritten before it was taken")
   `MOFB_ASSERT(a_wr_after_draw, clock, reset,
      (state_ff == ST_DRAW_WR) |-> $past(req_fire && req_data.kind == KIND_DRAW),
      "write-back without a draw beat")
   `MOFB_ASSERT(a_slot_range, clock, reset,
      (slot_ff <= SLOT_LAST) && (page_ff <= PAGE_LAST),
      "refresh position out of range")
   `MOFB_ASSERT_ALWAYS(a_reset_clears, clock,
      reset |=> (state_ff == ST_CLEAR && !rsp_valid_ff),
      "reset did not start the clearing pass")

endmodule

/* sim/mofb_checker.sv */
`timescale 1ns / 1ps
// Checker for the mono OLED frame buffer: mirrors the pixel store and compares refresh bytes.
module mofb_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  mofb_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mofb_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                bytes_due,
   output int                bytes_checked,
   output int                frames_seen
);
   import mofb_pkg::*;

   localparam int COLUMNS = 128;
   localparam int PAGES   = 8;

   logic [7:0] shadow_store [PAGES*COLUMNS];
   logic [2:0] scan_page;
   logic [7:0] scan_slot;
   rsp_type    refresh_due [$];

   task automatic wipe_store();
      for (int i = 0; i < PAGES*COLUMNS; i++) shadow_store[i] = '0;
      scan_page = '0;
      scan_slot = '0;
   endtask

   task automatic log_failure(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
   endtask

   // Applies one accepted request beat; an emit queues the refresh byte it must produce.
   task automatic take_request(input req_type beat);
      int         page;
      int         slot;
      int         idx;
      logic [7:0] mask;
      rsp_type    due;
      case (beat.kind)
         KIND_DRAW: begin
            if (beat.column < COLUMNS && beat.row < PAGES*8) begin
               page = PAGES - 1 - int'(beat.row >> 3);
               mask = 8'h80 >> beat.row[2:0];
               idx  = page*COLUMNS + int'(beat.column);
               if (beat.set_pixel) shadow_store[idx] = shadow_store[idx] | mask;
               else shadow_store[idx] = shadow_store[idx] & ~mask;
            end
         end
         KIND_CLEAR: wipe_store();
         KIND_EMIT: begin
            slot          = int'(scan_slot);
            due.is_data   = 1'b0;
            due.frame_end = 1'b0;
            case (slot)
               SLOT_PAGE_CMD: due.byte_out = CMD_PAGE_BASE + scan_page;
               SLOT_COL_LOW:  due.byte_out = CMD_COL_LOW;
               SLOT_COL_HIGH: due.byte_out = CMD_COL_HIGH;
               default: begin
                  due.byte_out = shadow_store[int'(scan_page)*COLUMNS + slot - HEADER_SLOTS];
                  due.is_data  = 1'b1;
               end
            endcase
            if (slot == HEADER_SLOTS + COLUMNS - 1) begin
               scan_slot = '0;
               if (scan_page == 3'(PAGES - 1)) begin
                  due.frame_end = 1'b1;
                  scan_page     = '0;
               end else begin
                  scan_page = scan_page + 1'b1;
               end
            end else begin
               scan_slot = scan_slot + 1'b1;
            end
            refresh_due.push_back(due);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         wipe_store();
         refresh_due.delete();
      end else begin
         // response first: it always belongs to an earlier request beat
         if (rsp_valid && rsp_ready) begin
            if (refresh_due.size() == 0) begin
               log_failure($sformatf("refresh byte %h with nothing outstanding",
                                     rsp_data.byte_out));
            end else begin
               want = refresh_due.pop_front();
               bytes_checked++;
               if (want.frame_end) frames_seen++;
               if (want.byte_out !== rsp_data.byte_out || want.is_data !== rsp_data.is_data ||
                   want.frame_end !== rsp_data.frame_end)
                  log_failure($sformatf(
                     "byte %0d: want %h data %b end %b, got %h data %b end %b",
                     bytes_checked, want.byte_out, want.is_data, want.frame_end,
                     rsp_data.byte_out, rsp_data.is_data, rsp_data.frame_end));
            end
         end
         if (req_valid && req_ready) take_request(req_data);
      end
      bytes_due = refresh_due.size();
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the mono OLED frame buffer: stimulus, back-pressure and verdict.
module tb;
   import mofb_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_BEATS = 1870;
   localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
   localparam int HOLD_BEATS   = 48;       // emits offered during the hold-off
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1_500_000;
   // a full frame is 8 pages of 131 bytes; no random clear before one has gone by
   localparam int FRAME_BEATS  = 1048;

   // kind code the block drops without effect
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // mix of beats within one random segment
   typedef enum int {MIX_PAINT, MIX_SCAN, MIX_NOISE} mix_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int error_count;
   int bytes_due;
   int bytes_checked;
   int frames_seen;
   int cycle_count = 0;

   // handshake between the stimulus and the receiver for the long hold-off
   bit hold_req    = 1'b0;
   bit hold_active = 1'b0;

   int beats_sent        = 0;
   int draws_sent        = 0;
   int emits_sent        = 0;
   int clears_sent       = 0;
   int spares_sent       = 0;
   int emits_since_clear = 0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   mono_oled_frame_buffer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   mofb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .bytes_due     (bytes_due),
      .bytes_checked (bytes_checked),
      .frames_seen   (frames_seen)
   );

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic req_type beat_of(input logic [1:0] kind, input logic [7:0] column,
                                       input logic [7:0] row, input logic set_pixel);
      req_type b;
      b.kind      = kind;
      b.column    = column;
      b.row       = row;
      b.set_pixel = set_pixel;
      return b;
   endfunction

   // Random beat for a segment. Unused fields carry junk; most draws land on the
   // panel, the rest take the full 8-bit range so the high coordinate bits toggle.
   function automatic req_type make_beat(input mix_type mix);
      req_type b;
      int      r;
      b = req_type'($urandom);
      r = $urandom_range(0, 99);
      case (mix)
         MIX_PAINT: b.kind = (r < 60) ? KIND_DRAW : KIND_EMIT;
         MIX_SCAN:  b.kind = (r < 94) ? KIND_EMIT : ((r < 98) ? KIND_DRAW : KIND_SPARE);
         default:   b.kind = (r < 40) ? KIND_DRAW : ((r < 75) ? KIND_EMIT : KIND_SPARE);
      endcase
      if (b.kind == KIND_DRAW && $urandom_range(0, 9) != 0) begin
         b.column = 8'($urandom_range(0, 127));
         b.row    = 8'($urandom_range(0, 63));
      end
      return b;
   endfunction

   // Offers one beat from the next falling edge until it is taken. A gap of zero
   // leaves valid high so the next call follows straight on; a caller that pauses
   // afterwards must pass a gap of at least one.
   task automatic send_beat(input req_type beat, input int gap);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      case (beat.kind)
         KIND_DRAW:  draws_sent++;
         KIND_CLEAR: begin
            clears_sent++;
            emits_since_clear = 0;
         end
         KIND_EMIT: begin
            emits_sent++;
            emits_since_clear++;
         end
         default:    spares_sent++;
      endcase
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= req_type'($urandom);   // junk on the idle bus
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Receiver: random ready pattern with quiet stretches, plus one long hold-off
   // on request, counted here so the sender keeps offering beats meanwhile.
   initial begin : receiver
      int g;
      int run;
      forever begin
         if (hold_req && !hold_active) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req    = 1'b0;
            hold_active = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            g = pick_gap();
            if (g > 0) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
               repeat (g - 1) @(negedge clock);
            end
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
            @(negedge clock);
            rsp_ready <= 1'b1;
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timed out after %0d cycles with %0d refresh bytes outstanding",
               cycle_count, bytes_due);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      req_type beat;
      mix_type mix;
      int      n;
      int      seg_left;
      int      gap;
      int      hold_at;
      int      r;
      bit      steady;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: panel corners, row boundaries, off-panel draws, darkening,
      // the spare kind, emits with junk fields, a clear and the rewound stream.
      send_beat(beat_of(KIND_DRAW, 8'd0, 8'd0, 1'b1), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd127, 8'd63, 1'b1), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd0, 8'd63, 1'b1), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd127, 8'd0, 1'b1), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd1, 8'd7, 1'b1), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd1, 8'd56, 1'b1), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd128, 8'd10, 1'b1), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd2, 8'd64, 1'b1), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd255, 8'd255, 1'b1), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd127, 8'd63, 1'b0), pick_gap());
      send_beat(beat_of(KIND_SPARE, 8'd0, 8'd63, 1'b1), pick_gap());
      // header of page 0, then its first data bytes
      repeat (7) send_beat(beat_of(KIND_EMIT, 8'hff, 8'hff, 1'b1), pick_gap());
      send_beat(beat_of(KIND_CLEAR, 8'hff, 8'hff, 1'b1), pick_gap());
      repeat (4) send_beat(beat_of(KIND_EMIT, 8'h00, 8'h00, 1'b0), pick_gap());
      send_beat(beat_of(KIND_DRAW, 8'd0, 8'd63, 1'b1), pick_gap());
      send_beat(beat_of(KIND_EMIT, 8'h55, 8'haa, 1'b0), pick_gap());

      // Random part, in segments of one mix. Some segments run with no idling.
      hold_at  = $urandom_range(500, 900);
      n        = 0;
      seg_left = 0;
      mix      = MIX_SCAN;
      steady   = 1'b0;
      while (n < RANDOM_BEATS) begin
         if (n == hold_at) begin
            // Receiver holds off; keep offering emits so the block backs up and
            // drops req_ready, then pause until every byte has been taken.
            hold_req = 1'b1;
            wait (hold_active);
            for (int i = 0; i < HOLD_BEATS; i++)
               send_beat(beat_of(KIND_EMIT, 8'($urandom), 8'($urandom), 1'($urandom)),
                         (i == HOLD_BEATS - 1) ? 1 : 0);
            wait (bytes_due == 0);
         end
         if (seg_left == 0) begin
            r = $urandom_range(0, 99);
            mix      = (r < 45) ? MIX_SCAN : ((r < 85) ? MIX_PAINT : MIX_NOISE);
            seg_left = $urandom_range(20, 120);
            steady   = ($urandom_range(0, 4) == 0);
            // an occasional clear, only once a whole frame has streamed out
            if (emits_since_clear > FRAME_BEATS && $urandom_range(0, 1) == 1) begin
               beat      = req_type'($urandom);
               beat.kind = KIND_CLEAR;
               send_beat(beat, steady ? 0 : pick_gap());
            end
         end
         beat = make_beat(mix);
         gap  = steady ? 0 : pick_gap();
         // valid must drop before a pause or the end
         if ((n + 1 == hold_at || n + 1 == RANDOM_BEATS) && gap == 0) gap = 1;
         send_beat(beat, gap);
         seg_left--;
         n++;
      end

      wait (bytes_due == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d beats: %0d draws, %0d emits, %0d clears, %0d spare-kind",
               beats_sent, draws_sent, emits_sent, clears_sent, spares_sent);
      $display("checked %0d refresh bytes over %0d full frames, %0d mismatches",
               bytes_checked, frames_seen, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
